/* src/char_lcd_4bit_sequencer_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the character LCD sequencer.
// Every macro samples on clk and is disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef CHAR_LCD_4BIT_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_4BIT_SEQUENCER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CLCD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/clcd_pkg.sv */
// ---------------------------------------------------------------------------
// clcd_pkg
// Types, pin constants and the step table of the character LCD sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package clcd_pkg;

    // Pin word bits
    localparam logic [7:0] PIN_RW  = 8'h10;
    localparam logic [7:0] PIN_RS  = 8'h20;
    localparam logic [7:0] PIN_E   = 8'h40;
    localparam logic [7:0] PIN_DB5 = 8'h02;

    // Fixed command bytes
    localparam logic [7:0] BYTE_FUNC_SET   = 8'h28;
    localparam logic [7:0] BYTE_DISP_ON    = 8'h0C;
    localparam logic [7:0] BYTE_ENTRY_MODE = 8'h06;
    localparam logic [7:0] BYTE_CLEAR      = 8'h01;
    localparam logic [7:0] BYTE_LINE0      = 8'h80;
    localparam logic [7:0] BYTE_LINE1      = 8'hC0;

    localparam int unsigned WAIT_W = 17;
    localparam logic [WAIT_W-1:0] WAIT_MIN = 17'd1;

    // Configuration register indexes
    localparam logic [1:0] CFG_POWER_ON_WAIT = 2'd0;
    localparam logic [1:0] CFG_CLEAR_WAIT    = 2'd1;
    localparam logic [1:0] CFG_BYTE_SETTLE   = 2'd2;

    // Last step index of each command
    localparam logic [5:0] LAST_STEP_INIT  = 6'd33;
    localparam logic [5:0] LAST_STEP_SHORT = 6'd6;

    typedef enum logic [1:0] {
        OP_INIT   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_CURSOR = 2'd2,
        OP_CLEAR  = 2'd3
    } opcode_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef enum logic [2:0] {
        PINOP_CLR_RW,
        PINOP_CLR_RS,
        PINOP_SET_RS,
        PINOP_SET_DB5,
        PINOP_E_HIGH,
        PINOP_E_LOW,
        PINOP_NIBBLE
    } pin_op_t;

    typedef enum logic [2:0] {
        BSEL_ARG,
        BSEL_FUNC,
        BSEL_DISP,
        BSEL_ENTRY,
        BSEL_CLEAR
    } byte_sel_t;

    typedef enum logic [2:0] {
        WSEL_ONE,
        WSEL_TWO,
        WSEL_POWER,
        WSEL_SETTLE,
        WSEL_SETTLE_CLEAR
    } wait_sel_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] char_code;
        logic       line_sel;
        logic [5:0] column;
    } cmd_t;

    typedef struct packed {
        logic [7:0]        pin_word;
        logic [WAIT_W-1:0] wait_us;
        logic              last;
    } pin_out_t;

    typedef struct packed {
        pin_op_t   op;
        byte_sel_t bsel;
        logic      hi;
        wait_sel_t wsel;
        logic      last;
    } step_t;

    typedef struct packed {
        logic  load_arg;
        logic  issue;
        step_t step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

    // One byte: nibble, pulse, nibble, pulse (six writes)
    function automatic step_t byte_step(byte_sel_t b, logic [2:0] p, logic clr_extra);
        step_t s;
        s.bsel = b;
        s.hi   = 1'b0;
        s.last = 1'b0;
        s.op   = PINOP_E_LOW;
        s.wsel = WSEL_SETTLE;
        unique case (p)
            3'd0:
            begin
                s.op   = PINOP_NIBBLE;
                s.hi   = 1'b1;
                s.wsel = WSEL_ONE;
            end
            3'd1, 3'd4:
            begin
                s.op   = PINOP_E_HIGH;
                s.wsel = WSEL_ONE;
            end
            3'd2:
            begin
                s.op   = PINOP_E_LOW;
                s.wsel = WSEL_SETTLE;
            end
            3'd3:
            begin
                s.op   = PINOP_NIBBLE;
                s.wsel = WSEL_ONE;
            end
            3'd5:
            begin
                s.op   = PINOP_E_LOW;
                s.wsel = clr_extra ? WSEL_SETTLE_CLEAR : WSEL_SETTLE;
            end
            default:
            begin
                s.op   = PINOP_E_LOW;
                s.wsel = WSEL_SETTLE;
            end
        endcase
        return s;
    endfunction

    function automatic step_t step_cmd(opcode_t op, logic [5:0] idx);
        step_t      s;
        logic [5:0] rel;
        byte_sel_t  b;
        s = byte_step(BSEL_ARG, 3'd0, 1'b0);
        rel = 6'd0;
        b = BSEL_ARG;
        unique case (op)
            OP_INIT:
            begin
                priority if (idx == 6'd0)
                begin
                    s.op   = PINOP_CLR_RW;
                    s.wsel = WSEL_ONE;
                end
                else if (idx == 6'd1)
                begin
                    s.op   = PINOP_CLR_RS;
                    s.wsel = WSEL_POWER;
                end
                else if (idx == 6'd2)
                begin
                    s.op   = PINOP_SET_DB5;
                    s.wsel = WSEL_ONE;
                end
                else if (idx == 6'd3 || idx == 6'd5 || idx == 6'd7)
                begin
                    s.op   = PINOP_E_HIGH;
                    s.wsel = WSEL_ONE;
                end
                else if (idx == 6'd4 || idx == 6'd6)
                begin
                    s.op   = PINOP_E_LOW;
                    s.wsel = WSEL_TWO;
                end
                else if (idx == 6'd8)
                begin
                    s.op   = PINOP_E_LOW;
                    s.wsel = WSEL_POWER;
                end
                else if (idx < 6'd15)
                begin
                    rel = idx - 6'd9;
                    s = byte_step(BSEL_FUNC, rel[2:0], 1'b0);
                end
                else if (idx < 6'd21)
                begin
                    rel = idx - 6'd15;
                    s = byte_step(BSEL_DISP, rel[2:0], 1'b0);
                end
                else if (idx < 6'd27)
                begin
                    rel = idx - 6'd21;
                    s = byte_step(BSEL_ENTRY, rel[2:0], 1'b0);
                end
                else if (idx == 6'd27)
                begin
                    s.op   = PINOP_CLR_RS;
                    s.wsel = WSEL_ONE;
                end
                else
                begin
                    rel = idx - 6'd28;
                    s = byte_step(BSEL_CLEAR, rel[2:0], 1'b1);
                end
                s.last = (idx == LAST_STEP_INIT);
            end
            OP_WRITE, OP_CURSOR, OP_CLEAR:
            begin
                b = (op == OP_CLEAR) ? BSEL_CLEAR : BSEL_ARG;
                if (idx == 6'd0)
                begin
                    s.op   = (op == OP_WRITE) ? PINOP_SET_RS : PINOP_CLR_RS;
                    s.wsel = WSEL_ONE;
                end
                else
                begin
                    rel = idx - 6'd1;
                    s = byte_step(b, rel[2:0], op == OP_CLEAR);
                end
                s.last = (idx == LAST_STEP_SHORT);
            end
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* src/clcd_ctrl.sv */
// ---------------------------------------------------------------------------
// clcd_ctrl
// Command sequencer: walks the step table of one command at a time.
// ---------------------------------------------------------------------------
`default_nettype none

module clcd_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cmd_valid,
    output logic                        cmd_ready,
    input  wire logic [1:0]             opcode,
    input  wire clcd_pkg::dp_status_t   status,
    output clcd_pkg::ctrl_cmd_t         ctl
);

    clcd_pkg::state_t  state_reg, state_next;
    clcd_pkg::opcode_t op_reg, op_next;
    logic [5:0]        step_reg, step_next;
    clcd_pkg::step_t   cur_step;

    assign cur_step = clcd_pkg::step_cmd(op_reg, step_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= clcd_pkg::ST_IDLE;
            op_reg    <= clcd_pkg::OP_INIT;
            step_reg  <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        step_next    = step_reg;
        cmd_ready    = 1'b0;
        ctl.load_arg = 1'b0;
        ctl.issue    = 1'b0;
        ctl.step     = cur_step;
        unique case (state_reg)
            clcd_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    ctl.load_arg = 1'b1;
                    op_next      = clcd_pkg::opcode_t'(opcode);
                    step_next    = 6'd0;
                    state_next   = clcd_pkg::ST_RUN;
                end
            end
            clcd_pkg::ST_RUN:
            begin
                if (!status.out_busy)
                begin
                    ctl.issue = 1'b1;
                    step_next = step_reg + 6'd1;
                    if (cur_step.last)
                        state_next = clcd_pkg::ST_IDLE;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/clcd_datapath.sv */
// ---------------------------------------------------------------------------
// clcd_datapath
// Pin register, configuration registers, wait arithmetic and output stage.
// ---------------------------------------------------------------------------
`default_nettype none

module clcd_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [15:0]          cfg_data,
    input  wire clcd_pkg::cmd_t       cmd_data,
    input  wire clcd_pkg::ctrl_cmd_t  ctl,
    output clcd_pkg::dp_status_t      status,
    output logic                      pin_valid,
    input  wire logic                 pin_ready,
    output clcd_pkg::pin_out_t        pin_data
);

    logic [15:0] power_on_wait_reg;
    logic [15:0] clear_wait_reg;
    logic [9:0]  byte_settle_reg;
    logic [7:0]  pin_state_reg, pin_state_next;
    logic [7:0]  arg_reg;
    logic        out_valid_reg, out_valid_next;
    clcd_pkg::pin_out_t out_reg;

    logic [7:0]                  cur_byte;
    logic [3:0]                  nib;
    logic [clcd_pkg::WAIT_W-1:0] wait_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_on_wait_reg <= 16'd15000;
            clear_wait_reg    <= 16'd2000;
            byte_settle_reg   <= 10'd100;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                clcd_pkg::CFG_POWER_ON_WAIT: power_on_wait_reg <= cfg_data;
                clcd_pkg::CFG_CLEAR_WAIT:    clear_wait_reg    <= cfg_data;
                clcd_pkg::CFG_BYTE_SETTLE:   byte_settle_reg   <= cfg_data[9:0];
                default:                     ;
            endcase
        end
    end

    // Argument byte: the character, or the cursor address
    always_ff @(posedge clk)
    begin
        if (ctl.load_arg)
        begin
            if (cmd_data.opcode == clcd_pkg::OP_WRITE)
                arg_reg <= cmd_data.char_code;
            else
                arg_reg <= (cmd_data.line_sel ? clcd_pkg::BYTE_LINE1 : clcd_pkg::BYTE_LINE0)
                           | {2'b00, cmd_data.column};
        end
    end

    always_comb
    begin
        unique case (ctl.step.bsel)
            clcd_pkg::BSEL_ARG:   cur_byte = arg_reg;
            clcd_pkg::BSEL_FUNC:  cur_byte = clcd_pkg::BYTE_FUNC_SET;
            clcd_pkg::BSEL_DISP:  cur_byte = clcd_pkg::BYTE_DISP_ON;
            clcd_pkg::BSEL_ENTRY: cur_byte = clcd_pkg::BYTE_ENTRY_MODE;
            clcd_pkg::BSEL_CLEAR: cur_byte = clcd_pkg::BYTE_CLEAR;
            default:              cur_byte = arg_reg;
        endcase
        nib = ctl.step.hi ? cur_byte[7:4] : cur_byte[3:0];
    end

    always_comb
    begin
        unique case (ctl.step.op)
            clcd_pkg::PINOP_CLR_RW:  pin_state_next = pin_state_reg & ~clcd_pkg::PIN_RW;
            clcd_pkg::PINOP_CLR_RS:  pin_state_next = pin_state_reg & ~clcd_pkg::PIN_RS;
            clcd_pkg::PINOP_SET_RS:  pin_state_next = pin_state_reg | clcd_pkg::PIN_RS;
            clcd_pkg::PINOP_SET_DB5: pin_state_next = pin_state_reg | clcd_pkg::PIN_DB5;
            clcd_pkg::PINOP_E_HIGH:  pin_state_next = pin_state_reg | clcd_pkg::PIN_E;
            clcd_pkg::PINOP_E_LOW:   pin_state_next = pin_state_reg & ~clcd_pkg::PIN_E;
            clcd_pkg::PINOP_NIBBLE:  pin_state_next = {pin_state_reg[7:4], nib};
            default:                 pin_state_next = pin_state_reg;
        endcase
    end

    // Hold time is 1 us plus the selected tail
    always_comb
    begin
        unique case (ctl.step.wsel)
            clcd_pkg::WSEL_ONE:
                wait_val = clcd_pkg::WAIT_MIN;
            clcd_pkg::WSEL_TWO:
                wait_val = clcd_pkg::WAIT_MIN + clcd_pkg::WAIT_MIN;
            clcd_pkg::WSEL_POWER:
                wait_val = {1'b0, power_on_wait_reg} + clcd_pkg::WAIT_MIN;
            clcd_pkg::WSEL_SETTLE:
                wait_val = {7'd0, byte_settle_reg} + clcd_pkg::WAIT_MIN;
            clcd_pkg::WSEL_SETTLE_CLEAR:
                wait_val = {7'd0, byte_settle_reg} + {1'b0, clear_wait_reg}
                           + clcd_pkg::WAIT_MIN;
            default:
                wait_val = clcd_pkg::WAIT_MIN;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.issue)
            out_valid_next = 1'b1;
        else if (pin_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_state_reg <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (ctl.issue)
                pin_state_reg <= pin_state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.issue)
        begin
            out_reg.pin_word <= pin_state_next;
            out_reg.wait_us  <= wait_val;
            out_reg.last     <= ctl.step.last;
        end
    end

    assign status.out_busy = out_valid_reg & ~pin_ready;
    assign pin_valid       = out_valid_reg;
    assign pin_data        = out_reg;

endmodule

`default_nettype wire

/* src/char_lcd_4bit_sequencer.sv */
// ---------------------------------------------------------------------------
// char_lcd_4bit_sequencer
// Turns LCD commands into timed pin writes for a 4-bit character display.
// ---------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd_data) takes one command: initialise,
//   write character, set cursor or clear. pin channel (pin_valid/pin_ready/
//   pin_data) delivers the pin writes of that command, each with its hold
//   time in us; last marks the final write of the command.
//   An accepted command moves the sequencer into its run state, which
//   issues the first write into the output register. Throughput: one write
//   per cycle while pin_ready is high, set by the step counter of the
//   sequencer; initialise gives 34 writes, the other commands 7.
//   The next command is taken once the last write has entered the output
//   register, even while that write still waits to be taken.
//   Stall: with pin_ready low the output register holds and the sequencer
//   waits; nothing is dropped.
//   Reset: pin register all low, timing registers at their defaults
//   (15000, 2000, 100 us). Config writes (cfg_we/cfg_index/cfg_data) take
//   effect at once and are meant for idle periods; index 3 is ignored.
// ---------------------------------------------------------------------------
`default_nettype none

module char_lcd_4bit_sequencer (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_ready,
    input  wire clcd_pkg::cmd_t      cmd_data,
    output logic                     pin_valid,
    input  wire logic                pin_ready,
    output clcd_pkg::pin_out_t       pin_data,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [15:0]         cfg_data
);

    clcd_pkg::ctrl_cmd_t  ctl;
    clcd_pkg::dp_status_t status;

    clcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .opcode    (cmd_data.opcode),
        .status    (status),
        .ctl       (ctl)
    );

    clcd_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_data  (cmd_data),
        .ctl       (ctl),
        .status    (status),
        .pin_valid (pin_valid),
        .pin_ready (pin_ready),
        .pin_data  (pin_data)
    );

`include "char_lcd_4bit_sequencer_assert.svh"

    // A new write is never issued over one that is still stalled
    `CLCD_ASSERT_SAME(a_no_overwrite, ctl.issue, !(pin_valid && !pin_ready), "write issued over stalled output")

    // Once a command is taken, the sequencer is busy in the next cycle
    `CLCD_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready, "ready stayed high after accept")

    // Every enable-high write is held exactly 1 us
    `CLCD_ASSERT_SAME(a_e_pulse_width, pin_valid && pin_data.pin_word[6], pin_data.wait_us == 17'd1, "enable pulse not 1 us")

endmodule

`default_nettype wire

/* dv/tb_char_lcd_4bit_sequencer.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_char_lcd_4bit_sequencer
// Drives LCD commands through the valid/ready command channel. A local
// predictor expands each accepted command into its pin writes. The monitor
// checks every pin write, field by field and in order, against that
// prediction. Several timing settings are used, the extremes among them,
// with random gaps on both channels except in the zero-timing run.
// ---------------------------------------------------------------------------
module tb_char_lcd_4bit_sequencer;

    typedef logic [clcd_pkg::WAIT_W-1:0] wait_t;

    localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cmd_valid = 1'b0;
    logic                cmd_ready;
    clcd_pkg::cmd_t      cmd_data  = '0;
    logic                pin_valid;
    logic                pin_ready = 1'b0;
    clcd_pkg::pin_out_t  pin_data;
    logic                cfg_we    = 1'b0;
    logic [1:0]          cfg_index = '0;
    logic [15:0]         cfg_data  = '0;

    // predictor state: pin register and timing registers
    logic [7:0]  lcd_pins    = 8'h00;
    logic [15:0] pwr_wait    = 16'd15000;
    logic [15:0] clr_wait    = 16'd2000;
    logic [9:0]  settle_wait = 10'd100;

    clcd_pkg::cmd_t      cmd_backlog[$];
    clcd_pkg::pin_out_t  pin_expect[$];
    clcd_pkg::pin_out_t  want;
    int unsigned cmd_gap   = 0;
    int unsigned ready_gap = 0;
    int unsigned err_cnt   = 0;
    bit          no_idle   = 1'b0;

    char_lcd_4bit_sequencer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .pin_valid (pin_valid),
        .pin_ready (pin_ready),
        .pin_data  (pin_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // mostly short gaps, a few long ones
    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic clcd_pkg::cmd_t mk_cmd(clcd_pkg::opcode_t op, logic [7:0] ch,
                                              logic ln, logic [5:0] col);
        clcd_pkg::cmd_t c;
        c.opcode    = op;
        c.char_code = ch;
        c.line_sel  = ln;
        c.column    = col;
        return c;
    endfunction

    function automatic clcd_pkg::cmd_t rand_cmd();
        clcd_pkg::cmd_t c;
        if ($urandom_range(0, 9) == 0)
            c.opcode = clcd_pkg::OP_INIT;
        else
            c.opcode = 2'($urandom_range(1, 3));
        c.char_code = 8'($urandom);
        c.line_sel  = 1'($urandom);
        c.column    = 6'($urandom);
        return c;
    endfunction

    task automatic put_pins(input logic [7:0] pins, input wait_t hold);
        clcd_pkg::pin_out_t r;
        lcd_pins   = pins;
        r.pin_word = pins;
        r.wait_us  = hold;
        r.last     = 1'b0;
        pin_expect.push_back(r);
    endtask

    // E high for 1 us, then E low for 1 us plus tail
    task automatic strobe_e(input wait_t tail);
        logic [7:0] base;
        base = lcd_pins;
        put_pins(base | clcd_pkg::PIN_E, clcd_pkg::WAIT_MIN);
        put_pins(base & ~clcd_pkg::PIN_E, clcd_pkg::WAIT_MIN + tail);
    endtask

    task automatic put_nibble(input logic [3:0] nib, input wait_t tail);
        put_pins((lcd_pins & 8'hF0) | {4'h0, nib}, clcd_pkg::WAIT_MIN);
        strobe_e(tail);
    endtask

    task automatic put_byte(input logic [7:0] b, input wait_t extra);
        put_nibble(b[7:4], wait_t'(settle_wait));
        put_nibble(b[3:0], wait_t'(settle_wait) + extra);
    endtask

    task automatic put_clear();
        put_pins(lcd_pins & ~clcd_pkg::PIN_RS, clcd_pkg::WAIT_MIN);
        put_byte(clcd_pkg::BYTE_CLEAR, wait_t'(clr_wait));
    endtask

    task automatic predict_cmd(input clcd_pkg::cmd_t c);
        clcd_pkg::pin_out_t fin;
        case (clcd_pkg::opcode_t'(c.opcode))
            clcd_pkg::OP_INIT:
            begin
                put_pins(lcd_pins & ~clcd_pkg::PIN_RW, clcd_pkg::WAIT_MIN);
                put_pins(lcd_pins & ~clcd_pkg::PIN_RS, clcd_pkg::WAIT_MIN + wait_t'(pwr_wait));
                // DB5 is ORed in, leftover data bits stay
                put_pins(lcd_pins | clcd_pkg::PIN_DB5, clcd_pkg::WAIT_MIN);
                strobe_e(wait_t'(1));
                strobe_e(wait_t'(1));
                strobe_e(wait_t'(pwr_wait));
                put_byte(clcd_pkg::BYTE_FUNC_SET, '0);
                put_byte(clcd_pkg::BYTE_DISP_ON, '0);
                put_byte(clcd_pkg::BYTE_ENTRY_MODE, '0);
                put_clear();
            end
            clcd_pkg::OP_WRITE:
            begin
                put_pins(lcd_pins | clcd_pkg::PIN_RS, clcd_pkg::WAIT_MIN);
                put_byte(c.char_code, '0);
            end
            clcd_pkg::OP_CURSOR:
            begin
                put_pins(lcd_pins & ~clcd_pkg::PIN_RS, clcd_pkg::WAIT_MIN);
                put_byte((c.line_sel ? clcd_pkg::BYTE_LINE1 : clcd_pkg::BYTE_LINE0)
                         | {2'b00, c.column}, '0);
            end
            default:
            begin
                put_clear();
            end
        endcase
        fin = pin_expect.pop_back();
        fin.last = 1'b1;
        pin_expect.push_back(fin);
    endtask

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd_gap   <= 0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
                predict_cmd(cmd_data);
            // a pending transaction holds valid and payload
            if (!cmd_valid || cmd_ready)
            begin
                if (cmd_gap != 0)
                begin
                    cmd_valid <= 1'b0;
                    cmd_gap   <= cmd_gap - 1;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    cmd_valid <= 1'b1;
                    cmd_data  <= cmd_backlog.pop_front();
                    cmd_gap   <= no_idle ? 0 : draw_gap();
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // pin write monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_ready <= 1'b0;
            ready_gap <= 0;
        end
        else
        begin
            if (pin_valid && pin_ready)
            begin
                if (pin_expect.size() == 0)
                begin
                    $display("%0t: unexpected pin write, actual %h", $time, pin_data);
                    err_cnt++;
                end
                else
                begin
                    want = pin_expect.pop_front();
                    if (pin_data.pin_word !== want.pin_word)
                    begin
                        $display("%0t: pin_word mismatch, expected %h actual %h",
                                 $time, want.pin_word, pin_data.pin_word);
                        err_cnt++;
                    end
                    if (pin_data.wait_us !== want.wait_us)
                    begin
                        $display("%0t: wait_us mismatch, expected %0d actual %0d",
                                 $time, want.wait_us, pin_data.wait_us);
                        err_cnt++;
                    end
                    if (pin_data.last !== want.last)
                    begin
                        $display("%0t: last mismatch, expected %b actual %b",
                                 $time, want.last, pin_data.last);
                        err_cnt++;
                    end
                end
            end
            if (ready_gap != 0)
            begin
                pin_ready <= 1'b0;
                ready_gap <= ready_gap - 1;
            end
            else
            begin
                pin_ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0)
                    ready_gap <= draw_gap();
            end
        end
    end

    task automatic set_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            clcd_pkg::CFG_POWER_ON_WAIT: pwr_wait    = val;
            clcd_pkg::CFG_CLEAR_WAIT:    clr_wait    = val;
            clcd_pkg::CFG_BYTE_SETTLE:   settle_wait = val[9:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait until every command is taken and every pin write checked
    task automatic wait_drained();
        do
            @(posedge clk);
        while (cmd_backlog.size() != 0 || cmd_valid || pin_expect.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic queue_random(input int unsigned n);
        repeat (n) cmd_backlog.push_back(rand_cmd());
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // defaults; data before init, then init with leftover nibble and RS set
        cmd_backlog.push_back(mk_cmd(clcd_pkg::OP_WRITE, 8'h00, 1'b0, 6'h00));
        cmd_backlog.push_back(mk_cmd(clcd_pkg::OP_WRITE, 8'hFF, 1'b1, 6'h3F));
        cmd_backlog.push_back(mk_cmd(clcd_pkg::OP_INIT, 8'hFF, 1'b1, 6'h3F));
        cmd_backlog.push_back(mk_cmd(clcd_pkg::OP_CURSOR, 8'hFF, 1'b0, 6'h00));
        cmd_backlog.push_back(mk_cmd(clcd_pkg::OP_CURSOR, 8'h00, 1'b1, 6'h3F));
        cmd_backlog.push_back(mk_cmd(clcd_pkg::OP_CURSOR, 8'hA5, 1'b0, 6'h3F));
        cmd_backlog.push_back(mk_cmd(clcd_pkg::OP_CURSOR, 8'h5A, 1'b1, 6'h00));
        cmd_backlog.push_back(mk_cmd(clcd_pkg::OP_WRITE, 8'hA5, 1'b1, 6'h2A));
        cmd_backlog.push_back(mk_cmd(clcd_pkg::OP_WRITE, 8'h5A, 1'b0, 6'h15));
        cmd_backlog.push_back(mk_cmd(clcd_pkg::OP_CLEAR, 8'hFF, 1'b1, 6'h3F));
        cmd_backlog.push_back(mk_cmd(clcd_pkg::OP_WRITE, 8'h80, 1'b0, 6'h00));
        cmd_backlog.push_back(mk_cmd(clcd_pkg::OP_WRITE, 8'h0F, 1'b1, 6'h3F));
        cmd_backlog.push_back(mk_cmd(clcd_pkg::OP_INIT, 8'h00, 1'b0, 6'h00));
        cmd_backlog.push_back(mk_cmd(clcd_pkg::OP_INIT, 8'h41, 1'b0, 6'h01));
        cmd_backlog.push_back(mk_cmd(clcd_pkg::OP_CLEAR, 8'h00, 1'b0, 6'h00));
        cmd_backlog.push_back(mk_cmd(clcd_pkg::OP_WRITE, 8'h7F, 1'b0, 6'h20));
        queue_random(35);
        wait_drained();

        // all timing at zero, no idling on either side
        no_idle = 1'b1;
        set_reg(clcd_pkg::CFG_POWER_ON_WAIT, 16'h0000);
        set_reg(clcd_pkg::CFG_CLEAR_WAIT, 16'h0000);
        set_reg(clcd_pkg::CFG_BYTE_SETTLE, 16'h0000);
        cmd_backlog.push_back(mk_cmd(clcd_pkg::OP_INIT, 8'h00, 1'b0, 6'h00));
        queue_random(35);
        wait_drained();

        // all timing at maximum; settle value is masked to 10 bits
        no_idle = 1'b0;
        set_reg(clcd_pkg::CFG_POWER_ON_WAIT, 16'hFFFF);
        set_reg(clcd_pkg::CFG_CLEAR_WAIT, 16'hFFFF);
        set_reg(clcd_pkg::CFG_BYTE_SETTLE, 16'hFFFF);
        set_reg(CFG_UNUSED_IDX, 16'($urandom));
        cmd_backlog.push_back(mk_cmd(clcd_pkg::OP_INIT, 8'hFF, 1'b1, 6'h3F));
        cmd_backlog.push_back(mk_cmd(clcd_pkg::OP_CLEAR, 8'h00, 1'b0, 6'h00));
        queue_random(35);
        wait_drained();

        set_reg(clcd_pkg::CFG_POWER_ON_WAIT, 16'($urandom));
        set_reg(clcd_pkg::CFG_CLEAR_WAIT, 16'($urandom));
        set_reg(clcd_pkg::CFG_BYTE_SETTLE, 16'($urandom));
        set_reg(CFG_UNUSED_IDX, 16'($urandom));
        queue_random(30);
        wait_drained();

        repeat (40) @(posedge clk);
        if (err_cnt == 0)
            $display("char_lcd_4bit_sequencer verification clean");
        else
            $display("char_lcd_4bit_sequencer verification failed");
        $finish;
    end

    initial
    begin
        #(4_000_000);
        $display("char_lcd_4bit_sequencer verification failed");
        $finish;
    end

endmodule

/* char_lcd_4bit_sequencer.f */
+incdir+src
src/clcd_pkg.sv
src/clcd_ctrl.sv
src/clcd_datapath.sv
src/char_lcd_4bit_sequencer.sv
dv/tb_char_lcd_4bit_sequencer.sv
